// ----- hdl/pdrtc_pkg.sv -----
package pdrtc_pkg;

  localparam int unsigned NumWakes = 4;

  localparam logic [31:0] RouteMask  = 32'h0f07_0f07;
  localparam logic [31:0] RouteReset = 32'h0f01_0000;
  localparam logic [3:0]  CtrlMask   = 4'h9;
  localparam logic [10:0] WakeBase   = 11'h330;
  localparam logic [10:0] WakeStride = 11'h008;
  localparam logic [10:0] WakeEnd    = 11'(WakeBase + NumWakes * WakeStride);

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_PIN   = 2'd3
  } op_e;

  typedef enum logic [10:0] {
    A_RST      = 11'h000,
    A_CTRL     = 11'h100,
    A_SEC      = 11'h104,
    A_MIN      = 11'h108,
    A_HOUR     = 11'h10c,
    A_DAY      = 11'h110,
    A_MON      = 11'h114,
    A_YEAR     = 11'h118,
    A_ASEC     = 11'h11c,
    A_AMIN     = 11'h120,
    A_AHOUR    = 11'h124,
    A_ADAY     = 11'h128,
    A_AMON     = 11'h12c,
    A_AYEAR    = 11'h130,
    A_FLAGS    = 11'h134,
    A_PCLR     = 11'h138,
    A_FEN      = 11'h13c,
    A_WSTAT    = 11'h310,
    A_WEN      = 11'h314,
    A_WCLR     = 11'h318,
    A_ROUTE    = 11'h31c,
    A_GPIO     = 11'h580
  } reg_addr_e;

  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic [4:0] day;
    logic [3:0] mon;
    logic [6:0] year;
  } caltime_t;

  localparam caltime_t TimeReset = '{sec: 6'd0, min: 6'd0, hour: 5'd0, day: 5'd1,
                                     mon: 4'd1, year: 7'd0};

  typedef struct packed {
    logic [31:0] rdata;
    logic        rtc_irq;
    logic        pdc_irq;
    logic        reset_request;
  } result_t;

  function automatic logic [4:0] month_len(logic [3:0] mon, logic [6:0] year);
    logic [4:0] l;
    case (mon)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: l = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    l = 5'd30;
      4'd2:    l = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
      default: l = 5'd0;
    endcase
    return l;
  endfunction

endpackage

// ----- hdl/pdrtc_cal.sv -----
module pdrtc_cal (
  input  pdrtc_pkg::caltime_t t_i,
  output pdrtc_pkg::caltime_t t_o,
  output logic                min_carry_o
);
  import pdrtc_pkg::*;

  logic [4:0] lim;

  always_comb begin
    t_o         = t_i;
    min_carry_o = 1'b0;
    lim         = month_len(t_i.mon, t_i.year);
    if ({1'b0, t_i.sec} + 7'd1 < 7'd60) begin
      t_o.sec = t_i.sec + 6'd1;
    end else begin
      t_o.sec     = '0;
      min_carry_o = 1'b1;
      if ({1'b0, t_i.min} + 7'd1 < 7'd60) begin
        t_o.min = t_i.min + 6'd1;
      end else begin
        t_o.min = '0;
        if ({1'b0, t_i.hour} + 6'd1 < 6'd24) begin
          t_o.hour = t_i.hour + 5'd1;
        end else begin
          t_o.hour = '0;
          if ({1'b0, t_i.day} + 6'd1 <= {1'b0, lim}) begin
            t_o.day = t_i.day + 5'd1;
          end else begin
            t_o.day = 5'd1;
            if ({1'b0, t_i.mon} + 5'd1 <= 5'd12) begin
              t_o.mon = t_i.mon + 4'd1;
            end else begin
              t_o.mon  = 4'd1;
              t_o.year = t_i.year + 7'd1;
            end
          end
        end
      end
    end
  end
endmodule

// ----- hdl/powerdown_rtc_wake_controller_core.sv -----
// path: a transferred input passes the input register, then the result register
// throughput: one item per cycle while the skid slot is free; the whole event is handled by the register update logic
// stalls: a result held by the receiver parks the next one in a skid slot, then ready drops
// reset: asynchronous active low; time, preset and alarm reset to 0:00:00 day 1 month 1 year 0,
// clock enabled, route word 0x0f010000, wake modes 4 (no interrupt), all else zero
module powerdown_rtc_wake_controller_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [1:0]  op_i,
  input  logic [10:0] addr_i,
  input  logic [31:0] wdata_i,
  input  logic [1:0]  pin_index_i,
  input  logic        pin_level_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [31:0] rdata_o,
  output logic        rtc_irq_o,
  output logic        pdc_irq_o,
  output logic        reset_request_o
);
  import pdrtc_pkg::*;

  // input register
  logic        in_v_q;
  logic [1:0]  op_q;
  logic [10:0] addr_q;
  logic [31:0] wdata_q;
  logic [1:0]  pin_q;
  logic        lvl_q;

  // result buffer: main slot plus skid slot
  result_t res_q, skid_q, res_d;
  logic    res_v_q, skid_v_q;
  logic    adv;

  // the input stage advances when the skid slot is free
  assign ready_o = !skid_v_q;
  assign adv     = ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (adv) begin
      in_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      op_q    <= op_i;
      addr_q  <= {addr_i[10:2], 2'b00};
      wdata_q <= wdata_i;
      pin_q   <= pin_index_i;
      lvl_q   <= pin_level_i;
    end
  end

  // a valid item in the input register is processed in a cycle in which the skid slot is free
  logic go;
  assign go = in_v_q && adv;

  pdrtc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (go),
    .op_i    (op_q),
    .addr_i  (addr_q),
    .wdata_i (wdata_q),
    .pin_i   (pin_q),
    .lvl_i   (lvl_q),
    .res_o   (res_d)
  );

  // output skid: if the main slot is held, the new result lands in skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (!res_v_q || ready_i) begin
        res_v_q  <= skid_v_q || go;
        skid_v_q <= 1'b0;
      end else if (go) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!res_v_q || ready_i) begin
      res_q <= skid_v_q ? skid_q : res_d;
    end else if (go) begin
      skid_q <= res_d;
    end
  end

  assign valid_o         = res_v_q;
  assign rdata_o         = res_q.rdata;
  assign rtc_irq_o       = res_q.rtc_irq;
  assign pdc_irq_o       = res_q.pdc_irq;
  assign reset_request_o = res_q.reset_request;
endmodule

// ----- hdl/pdrtc_regs.sv -----
module pdrtc_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               go_i,
  input  logic [1:0]         op_i,
  input  logic [10:0]        addr_i,
  input  logic [31:0]        wdata_i,
  input  logic [1:0]         pin_i,
  input  logic               lvl_i,
  output pdrtc_pkg::result_t res_o
);
  import pdrtc_pkg::*;

  caltime_t    run_q, run_d, pre_q, pre_d, alm_q, alm_d, run_nx;
  logic [5:0]  aen_q, aen_d;
  logic [3:0]  ctl_q, ctl_d;
  logic [2:0]  flg_q, flg_d, pcl_q, pcl_d, fen_q, fen_d;
  logic        rr_q, rr_d;
  logic [3:0]  wf_q, wf_d, em_q, em_d, wl_q, wl_d;
  logic [31:0] wen_q, wen_d, route_q, route_d;
  logic [2:0]  wm_q [NumWakes], wm_d [NumWakes];
  logic        min_c;
  logic [31:0] rd;
  logic        rst_req;

  pdrtc_cal u_cal (.t_i(run_q), .t_o(run_nx), .min_carry_o(min_c));

  logic       wslot;
  logic [1:0] wn;
  caltime_t   vt;
  logic       match, fire;
  logic [2:0] f;
  logic [2:0] pc;
  logic [10:0] woff;

  always_comb begin
    run_d = run_q; pre_d = pre_q; alm_d = alm_q; aen_d = aen_q; ctl_d = ctl_q;
    flg_d = flg_q; pcl_d = pcl_q; fen_d = fen_q; rr_d = rr_q; wf_d = wf_q;
    em_d = em_q; wl_d = wl_q; wen_d = wen_q; route_d = route_q;
    for (int i = 0; i < NumWakes; i++) wm_d[i] = wm_q[i];
    rd = '0; rst_req = 1'b0; match = 1'b0; fire = 1'b0; f = '0; pc = '0;
    wslot = (addr_i >= WakeBase) && (addr_i < WakeEnd);
    woff  = addr_i - WakeBase;
    wn    = woff[4:3];
    vt    = ctl_q[0] ? run_q : pre_q;
    case (op_e'(op_i))
      OP_READ: begin
        if (wslot) begin
          if (!addr_i[2]) rd = {28'd0, wm_q[wn], wl_q[wn]};
        end else begin
          case (addr_i)
            A_CTRL:  rd = {28'd0, ctl_q};
            A_SEC:   rd = {26'd0, vt.sec};
            A_MIN:   rd = {26'd0, vt.min};
            A_HOUR:  rd = {27'd0, vt.hour};
            A_DAY:   rd = {27'd0, vt.day};
            A_MON:   rd = {28'd0, vt.mon};
            A_YEAR:  rd = {25'd0, vt.year};
            A_ASEC:  rd = {25'd0, aen_q[0], alm_q.sec};
            A_AMIN:  rd = {25'd0, aen_q[1], alm_q.min};
            A_AHOUR: rd = {26'd0, aen_q[2], alm_q.hour};
            A_ADAY:  rd = {26'd0, aen_q[3], alm_q.day};
            A_AMON:  rd = {27'd0, aen_q[4], alm_q.mon};
            A_AYEAR: rd = {24'd0, aen_q[5], alm_q.year};
            A_FLAGS: rd = {29'd0, flg_q};
            A_PCLR:  rd = {29'd0, pcl_q};
            A_FEN:   rd = {29'd0, fen_q};
            A_WSTAT: rd = {28'd0, wf_q & wen_q[3:0]};
            A_WEN:   rd = wen_q;
            A_ROUTE: rd = route_q;
            A_GPIO:  rd = {26'd0, wl_q, 2'b00};
            default: rd = '0;
          endcase
        end
      end
      OP_WRITE: begin
        if (wslot) begin
          if (!addr_i[2]) begin
            wm_d[wn] = wdata_i[3:1];
            em_d[wn] = wdata_i[2];
          end
        end else begin
          case (addr_i)
            A_RST:  rst_req = wdata_i[0];
            A_CTRL: begin
              ctl_d = wdata_i[3:0] & CtrlMask;
              if (wdata_i[1]) run_d = pre_q;
              if ((wdata_i[0] ^ ctl_q[0]) && wdata_i[0]) begin
                if (flg_q[2] && pcl_q[2]) begin
                  flg_d[2] = 1'b0;
                  pcl_d    = pcl_q & flg_d;
                end
                run_d = pre_q;
              end
            end
            A_SEC:   pre_d.sec  = wdata_i[5:0];
            A_MIN:   pre_d.min  = wdata_i[5:0];
            A_HOUR:  pre_d.hour = wdata_i[4:0];
            A_DAY:   pre_d.day  = wdata_i[4:0];
            A_MON:   pre_d.mon  = wdata_i[3:0];
            A_YEAR:  pre_d.year = wdata_i[6:0];
            A_ASEC:  begin alm_d.sec  = wdata_i[5:0]; aen_d[0] = wdata_i[6]; end
            A_AMIN:  begin alm_d.min  = wdata_i[5:0]; aen_d[1] = wdata_i[6]; end
            A_AHOUR: begin alm_d.hour = wdata_i[4:0]; aen_d[2] = wdata_i[5]; end
            A_ADAY:  begin alm_d.day  = wdata_i[4:0]; aen_d[3] = wdata_i[5]; end
            A_AMON:  begin alm_d.mon  = wdata_i[3:0]; aen_d[4] = wdata_i[4]; end
            A_AYEAR: begin alm_d.year = wdata_i[6:0]; aen_d[5] = wdata_i[7]; end
            A_FLAGS: flg_d = flg_q | wdata_i[2:0];
            A_PCLR: begin
              pc = pcl_q | wdata_i[2:0];
              f  = flg_q & ~(pc & 3'b011);
              if (ctl_q[0]) f = f & ~(pc & 3'b100);
              flg_d = f;
              pcl_d = pc & f;
            end
            A_FEN:   fen_d = wdata_i[2:0];
            A_WEN:   wen_d = wdata_i;
            A_WCLR:  wf_d  = wf_q & ~(wdata_i[3:0] & em_q);
            A_ROUTE: begin
              route_d = wdata_i & RouteMask;
              if (route_q[0] ^ wdata_i[0]) rr_d = wdata_i[0];
            end
            default: ;
          endcase
        end
      end
      OP_TICK: begin
        if (ctl_q[0]) begin
          run_d = run_nx;
          f = flg_q | (fen_q & {1'b0, min_c, 1'b1});
          match = ctl_q[3] && fen_q[2]
               && (!aen_q[0] || run_nx.sec  == alm_q.sec)
               && (!aen_q[1] || run_nx.min  == alm_q.min)
               && (!aen_q[2] || run_nx.hour == alm_q.hour)
               && (!aen_q[3] || run_nx.day  == alm_q.day)
               && (!aen_q[4] || run_nx.mon  == alm_q.mon)
               && (!aen_q[5] || run_nx.year == alm_q.year);
          flg_d = f | {match, 2'b00};
        end
      end
      default: begin
        if ((32'(pin_i) < NumWakes) && (wl_q[pin_i] != lvl_i)) begin
          wl_d[pin_i] = lvl_i;
          case (wm_q[pin_i])
            3'd0, 3'd2: fire = !lvl_i;
            3'd1, 3'd3: fire = lvl_i;
            3'd6, 3'd7: fire = 1'b1;
            default:    fire = 1'b0;
          endcase
          if (fire) wf_d[pin_i] = 1'b1;
        end
      end
    endcase
    res_o.rdata         = rd;
    res_o.rtc_irq       = !rr_d && ((flg_d & fen_d) != 3'd0);
    res_o.pdc_irq       = (wf_d & wen_d[3:0]) != 4'd0;
    res_o.reset_request = rst_req;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= TimeReset; pre_q <= TimeReset; alm_q <= TimeReset;
      aen_q <= '0; ctl_q <= 4'h1; flg_q <= '0; pcl_q <= '0; fen_q <= '0;
      rr_q <= 1'b0; wf_q <= '0; em_q <= '0; wl_q <= '0; wen_q <= '0;
      route_q <= RouteReset;
      for (int i = 0; i < NumWakes; i++) wm_q[i] <= 3'd4;
    end else if (go_i) begin
      run_q <= run_d; pre_q <= pre_d; alm_q <= alm_d;
      aen_q <= aen_d; ctl_q <= ctl_d; flg_q <= flg_d; pcl_q <= pcl_d; fen_q <= fen_d;
      rr_q <= rr_d; wf_q <= wf_d; em_q <= em_d; wl_q <= wl_d; wen_q <= wen_d;
      route_q <= route_d;
      for (int i = 0; i < NumWakes; i++) wm_q[i] <= wm_d[i];
    end
  end
endmodule

// ----- hdl/pdrtc_checker.sv -----
module pdrtc_props (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        ready_o,
  input logic        valid_o,
  input logic        ready_i,
  input logic [31:0] rdata_o,
  input logic        reset_request_o
);
  // result held while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(rdata_o))
    else $error("result changed while stalled");

  // no result without a preceding transfer
  a_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_o) |-> $past(valid_i && ready_o, 2) || $past(valid_i && ready_o))
    else $error("result without input transfer");

  // read data and reset request never together
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && reset_request_o |-> rdata_o == 32'd0)
    else $error("reset request with read data");

  // input is always ready when nothing waits at the output
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> ready_o)
    else $error("input stalled with empty output");
endmodule

bind powerdown_rtc_wake_controller_core pdrtc_props u_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .valid_i         (valid_i),
  .ready_o         (ready_o),
  .valid_o         (valid_o),
  .ready_i         (ready_i),
  .rdata_o         (rdata_o),
  .reset_request_o (reset_request_o)
);

// ----- test/pdrtc_checker.sv -----
`timescale 1ns / 100ps

module pdrtc_checker
  import pdrtc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic        ready_o,
  input  logic [1:0]  op_i,
  input  logic [10:0] addr_i,
  input  logic [31:0] wdata_i,
  input  logic [1:0]  pin_index_i,
  input  logic        pin_level_i,
  input  logic        valid_o,
  input  logic        ready_i,
  input  logic [31:0] rdata_o,
  input  logic        rtc_irq_o,
  input  logic        pdc_irq_o,
  input  logic        reset_request_o,
  output int          fail_count,
  output int          pending,
  output int          result_count
);

  localparam logic [3:0] CeBit  = 4'h1;
  localparam logic [3:0] GaeBit = 4'h8;
  localparam logic [2:0] FSec   = 3'h1;
  localparam logic [2:0] FMin   = 3'h2;
  localparam logic [2:0] FAlarm = 3'h4;

  // shadow copy of the controller state
  caltime_t    run_t, pre_t, alm_t;
  logic [5:0]  alm_en;
  logic [3:0]  ctrl;
  logic [2:0]  flags, pclr, fen;
  logic        rerouted;
  logic [3:0]  wflags, edge_m, levels;
  logic [31:0] wen, route;
  logic [2:0]  modes [4];

  result_t expected_results[$];

  function automatic logic [4:0] days_in(logic [3:0] m, logic [6:0] y);
    case (m)
      4'd2:                                 return (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:              return 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
      default:                              return 5'd0;
    endcase
  endfunction

  task automatic tick_second();
    flags = flags | (fen & FSec);
    if (run_t.sec + 7'd1 < 7'd60) begin
      run_t.sec++;
      return;
    end
    run_t.sec = '0;
    flags = flags | (fen & FMin);
    if (run_t.min + 7'd1 < 7'd60) begin
      run_t.min++;
      return;
    end
    run_t.min = '0;
    if (run_t.hour + 6'd1 < 6'd24) begin
      run_t.hour++;
      return;
    end
    run_t.hour = '0;
    if (run_t.day + 6'd1 <= {1'b0, days_in(run_t.mon, run_t.year)}) begin
      run_t.day++;
      return;
    end
    run_t.day = 5'd1;
    if (run_t.mon + 5'd1 <= 5'd12) begin
      run_t.mon++;
      return;
    end
    run_t.mon = 4'd1;
    run_t.year++;
  endtask

  task automatic match_alarm();
    if (!(ctrl & GaeBit) || !(fen & FAlarm)) return;
    if (alm_en[0] && run_t.sec != alm_t.sec) return;
    if (alm_en[1] && run_t.min != alm_t.min) return;
    if (alm_en[2] && run_t.hour != alm_t.hour) return;
    if (alm_en[3] && run_t.day != alm_t.day) return;
    if (alm_en[4] && run_t.mon != alm_t.mon) return;
    if (alm_en[5] && run_t.year != alm_t.year) return;
    flags = flags | FAlarm;
  endtask

  function automatic logic [31:0] alarm_word(logic [6:0] v, int b, int e);
    logic [31:0] r;
    r = 32'(v);
    if (alm_en[e]) r[b] = 1'b1;
    return r;
  endfunction

  function automatic logic [31:0] read_reg(logic [10:0] a);
    caltime_t vt;
    logic [1:0] n;
    vt = (ctrl & CeBit) ? run_t : pre_t;
    if (a >= WakeBase && a < WakeEnd) begin
      n = 2'((a - WakeBase) >> 3);
      if (a[2]) return '0;
      return {28'd0, modes[n], levels[n]};
    end
    case (a)
      A_CTRL:  return 32'(ctrl);
      A_SEC:   return 32'(vt.sec);
      A_MIN:   return 32'(vt.min);
      A_HOUR:  return 32'(vt.hour);
      A_DAY:   return 32'(vt.day);
      A_MON:   return 32'(vt.mon);
      A_YEAR:  return 32'(vt.year);
      A_ASEC:  return alarm_word(7'(alm_t.sec), 6, 0);
      A_AMIN:  return alarm_word(7'(alm_t.min), 6, 1);
      A_AHOUR: return alarm_word(7'(alm_t.hour), 5, 2);
      A_ADAY:  return alarm_word(7'(alm_t.day), 5, 3);
      A_AMON:  return alarm_word(7'(alm_t.mon), 4, 4);
      A_AYEAR: return alarm_word(alm_t.year, 7, 5);
      A_FLAGS: return 32'(flags);
      A_PCLR:  return 32'(pclr);
      A_FEN:   return 32'(fen);
      A_WSTAT: return 32'(wflags) & wen;
      A_WEN:   return wen;
      A_ROUTE: return route;
      A_GPIO:  return 32'(levels) << 2;
      default: return '0;
    endcase
  endfunction

  function automatic logic write_reg(logic [10:0] a, logic [31:0] v);
    logic [31:0] diff;
    logic [1:0]  n;
    if (a >= WakeBase && a < WakeEnd) begin
      n = 2'((a - WakeBase) >> 3);
      if (!a[2]) begin
        modes[n] = v[3:1];
        edge_m[n] = v[2];
      end
      return 1'b0;
    end
    case (a)
      A_RST: return v[0];
      A_CTRL: begin
        diff = v ^ 32'(ctrl);
        ctrl = v[3:0] & CtrlMask;
        if (v[1]) run_t = pre_t;
        if (diff[0] && v[0]) begin
          if (flags & pclr & FAlarm) begin
            flags = flags & ~FAlarm;
            pclr = pclr & flags;
          end
          run_t = pre_t;
        end
      end
      A_SEC:   pre_t.sec = v[5:0];
      A_MIN:   pre_t.min = v[5:0];
      A_HOUR:  pre_t.hour = v[4:0];
      A_DAY:   pre_t.day = v[4:0];
      A_MON:   pre_t.mon = v[3:0];
      A_YEAR:  pre_t.year = v[6:0];
      A_ASEC: begin alm_t.sec = v[5:0];  alm_en[0] = v[6]; end
      A_AMIN: begin alm_t.min = v[5:0];  alm_en[1] = v[6]; end
      A_AHOUR: begin alm_t.hour = v[4:0]; alm_en[2] = v[5]; end
      A_ADAY: begin alm_t.day = v[4:0];  alm_en[3] = v[5]; end
      A_AMON: begin alm_t.mon = v[3:0];  alm_en[4] = v[4]; end
      A_AYEAR: begin alm_t.year = v[6:0]; alm_en[5] = v[7]; end
      A_FLAGS: flags = flags | v[2:0];
      A_PCLR: begin
        pclr = pclr | v[2:0];
        flags = flags & ~(pclr & ~FAlarm);
        if (ctrl & CeBit) flags = flags & ~(pclr & FAlarm);
        pclr = pclr & flags;
      end
      A_FEN:   fen = v[2:0];
      A_WEN:   wen = v;
      A_WCLR:  wflags = wflags & ~(v[3:0] & edge_m);
      A_ROUTE: begin
        diff = route ^ v;
        route = v & RouteMask;
        if (diff[0]) rerouted = v[0];
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  task automatic wake_pin(logic [1:0] n, logic lvl);
    logic fire;
    if (levels[n] == lvl) return;
    levels[n] = lvl;
    case (modes[n])
      3'd0, 3'd2: fire = !lvl;
      3'd1, 3'd3: fire = lvl;
      3'd6, 3'd7: fire = 1'b1;
      default:    fire = 1'b0;
    endcase
    if (fire) wflags[n] = 1'b1;
  endtask

  // compute the result of one accepted event
  task automatic predict_event(op_e op, logic [10:0] a, logic [31:0] v,
                               logic [1:0] n, logic lvl);
    result_t r;
    r = '0;
    case (op)
      OP_READ:  r.rdata = read_reg(a);
      OP_WRITE: r.reset_request = write_reg(a, v);
      OP_TICK: begin
        if (ctrl & CeBit) begin
          tick_second();
          match_alarm();
        end
      end
      default: wake_pin(n, lvl);
    endcase
    r.rtc_irq = !rerouted && ((flags & fen) != '0);
    r.pdc_irq = (32'(wflags) & wen) != '0;
    expected_results.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t e;
    if (!rst_ni) begin
      run_t = TimeReset; pre_t = TimeReset; alm_t = TimeReset;
      alm_en = '0; ctrl = CeBit; flags = '0; pclr = '0; fen = '0;
      rerouted = 1'b0; wflags = '0; wen = '0; edge_m = '0; levels = '0;
      route = RouteReset;
      for (int i = 0; i < 4; i++) modes[i] = 3'd4;
      expected_results.delete();
      pending = 0;
      fail_count <= 0;
      result_count <= 0;
    end else begin
      // check the output side first; the new event lands at the back
      if (valid_o && ready_i) begin
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("result transfer with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_results.pop_front();
          if (e.rdata !== rdata_o || e.rtc_irq !== rtc_irq_o ||
              e.pdc_irq !== pdc_irq_o || e.reset_request !== reset_request_o) begin
            if (fail_count < 10)
              $display("mismatch: exp rdata %h rtc %b pdc %b rst %b, got %h %b %b %b",
                       e.rdata, e.rtc_irq, e.pdc_irq, e.reset_request,
                       rdata_o, rtc_irq_o, pdc_irq_o, reset_request_o);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (valid_i && ready_o)
        predict_event(op_e'(op_i), {addr_i[10:2], 2'b00}, wdata_i, pin_index_i, pin_level_i);
      pending = expected_results.size();
    end
  end

endmodule

// ----- test/tb_powerdown_rtc_wake_controller_core.sv -----
`timescale 1ns / 100ps

module tb_powerdown_rtc_wake_controller_core;
  import pdrtc_pkg::*;

  logic        clk_i, rst_ni;
  logic        valid_i, ready_o, valid_o, ready_i;
  logic [1:0]  op_i, pin_index_i;
  logic [10:0] addr_i;
  logic [31:0] wdata_i, rdata_o;
  logic        pin_level_i, rtc_irq_o, pdc_irq_o, reset_request_o;
  int          fail_count, pending, result_count;
  int          sent, stall_cycles, idle_cycles;
  logic        calm;   // no idling on either side during this stretch
  logic        hold_off;

  powerdown_rtc_wake_controller_core dut (.*);

  pdrtc_checker u_checker (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // receiver: random stalls, with a long hold-off on request
  initial begin
    ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) ready_i <= 1'b0;
      else ready_i <= calm || ($urandom_range(99) >= 13);
    end
  end

  // watchdog: cycles with no transfer on either channel
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((valid_i && ready_o) || (valid_o && ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 2000) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // one event transfer; valid stays up until accepted
  task automatic send_event(op_e op, logic [10:0] a, logic [31:0] v,
                            logic [1:0] n, logic lvl);
    while (!calm && $urandom_range(99) < 13) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    op_i <= op;
    addr_i <= a;
    wdata_i <= v;
    pin_index_i <= n;
    pin_level_i <= lvl;
    do @(posedge clk_i); while (!ready_o);
    sent++;
  endtask

  task automatic wr(logic [10:0] a, logic [31:0] v);
    send_event(OP_WRITE, a, v, 2'($urandom), 1'($urandom));
  endtask

  task automatic rd(logic [10:0] a);
    send_event(OP_READ, a, $urandom, 2'($urandom), 1'($urandom));
  endtask

  task automatic tick();
    send_event(OP_TICK, 11'($urandom), $urandom, 2'($urandom), 1'($urandom));
  endtask

  task automatic pin(logic [1:0] n, logic lvl);
    send_event(OP_PIN, 11'($urandom), $urandom, n, lvl);
  endtask

  // register offsets that are mapped, plus addresses in and just past the wake slots; sometimes any address
  function automatic logic [10:0] pick_addr();
    logic [10:0] tbl [26];
    tbl = '{A_RST, A_CTRL, A_SEC, A_MIN, A_HOUR, A_DAY, A_MON, A_YEAR, A_ASEC, A_AMIN,
            A_AHOUR, A_ADAY, A_AMON, A_AYEAR, A_FLAGS, A_PCLR, A_FEN, A_WSTAT, A_WEN,
            A_WCLR, A_ROUTE, A_GPIO, 11'h330, 11'h33c, 11'h348, 11'h350};
    if ($urandom_range(9) == 0) return 11'($urandom);
    return tbl[$urandom_range(25)] | 11'($urandom_range(3));
  endfunction

  // random wdata biased toward small legal field values
  function automatic logic [31:0] pick_data(logic [10:0] a);
    if ($urandom_range(3) == 0) return $urandom;
    case ({a[10:2], 2'b00})
      A_CTRL:  return 32'($urandom_range(15));
      A_SEC, A_MIN: return 32'($urandom_range(59));
      A_HOUR:  return 32'($urandom_range(23));
      A_DAY:   return 32'($urandom_range(31, 1));
      A_MON:   return 32'($urandom_range(12, 1));
      default: return 32'($urandom_range(255));
    endcase
  endfunction

  initial begin
    int k;
    logic [10:0] a;
    rst_ni = 1'b0;
    valid_i = 1'b0;
    op_i = OP_READ;
    addr_i = '0;
    wdata_i = '0;
    pin_index_i = '0;
    pin_level_i = 1'b0;
    calm = 1'b0;
    hold_off = 1'b0;
    sent = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: calendar rollover at year end with year wrap, alarm, wake pins
    wr(A_RST, 32'h1);
    wr(A_FEN, 32'h7);
    wr(A_YEAR, 32'h7f);
    wr(A_MON, 32'd12);
    wr(A_DAY, 32'd31);
    wr(A_HOUR, 32'd23);
    wr(A_MIN, 32'd59);
    wr(A_SEC, 32'd59);
    wr(A_AYEAR, 32'h80);
    wr(A_CTRL, 32'hb);
    tick();
    rd(A_YEAR);
    rd(A_FLAGS);
    wr(A_PCLR, 32'h7);
    wr(11'h330, 32'h6);
    wr(A_WEN, 32'hffff_ffff);
    pin(2'd0, 1'b1);
    pin(2'd0, 1'b0);
    rd(A_WSTAT);
    wr(A_WCLR, 32'hf);
    wr(A_ROUTE, 32'hffff_ffff);
    rd(A_ROUTE);
    rd(A_GPIO);
    wr(A_CTRL, 32'h0);
    tick();

    // random events; a calm stretch, a long receiver hold-off, a drain pause
    for (int i = 0; i < 1200; i++) begin
      calm = (i >= 300 && i < 450);
      if (i == 600) begin
        hold_off = 1'b1;
        fork
          begin
            stall_cycles = 0;
            while (stall_cycles < 60) begin
              @(posedge clk_i);
              stall_cycles++;
            end
            hold_off = 1'b0;
          end
        join_none
      end
      if (i == 900) begin
        valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      k = $urandom_range(99);
      if (k < 35) tick();
      else if (k < 60) pin(2'($urandom), 1'($urandom));
      else if (k < 80) begin
        a = pick_addr();
        wr(a, pick_data(a));
      end else rd(pick_addr());
    end

    valid_i <= 1'b0;
    @(posedge clk_i);
    k = 0;
    while (pending != 0 && k < 5000) begin
      @(posedge clk_i);
      k++;
    end
    repeat (5) @(posedge clk_i);
    $display("sent %0d events (reads, writes, ticks, pin changes), checked %0d results",
             sent, result_count);
    if (fail_count == 0 && pending == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/pdrtc_pkg.sv
hdl/pdrtc_cal.sv
hdl/powerdown_rtc_wake_controller_core.sv
hdl/pdrtc_regs.sv
hdl/pdrtc_checker.sv
test/pdrtc_checker.sv
test/tb_powerdown_rtc_wake_controller_core.sv
